// File: hdl/ssort_pkg.sv
// Shared constants and types for the selection sort engine.
// Depends on nothing; in hdl, only selection_sort_engine imports it.
`timescale 1ns / 1ps

package ssort_pkg;

  // Store geometry.
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Count-width forms of the store depth, of one and of two.
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_CNT   = CNT_W'(2);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,   // collecting values
    S_LOAD,   // read the element at the current position
    S_FIRST,  // capture it as the running minimum, start the scan
    S_SCAN,   // one compare per cycle against the running minimum
    S_SWAP1,  // write the minimum into the current position
    S_SWAP2,  // write the displaced value where the minimum was
    S_EMIT    // read out the sorted set, one result per cycle
  } state_t;

endpackage

// File: hdl/ssort_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module ssort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/selection_sort_engine.sv
// Selection sort engine: collects a set of signed values and emits them sorted.
// Sorting after the last value of a set runs one compare per cycle through the single
// store read port, then the stored values come out on consecutive cycles. Throughput is
// one set at a time; busy is high from the last value until the final read is issued.
// Values are taken while collecting, whenever start is high.
// Synchronous active-low reset empties the set; store contents are kept and unused.
// Depends on ssort_pkg and ssort_ram.
`timescale 1ns / 1ps

module selection_sort_engine
  import ssort_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_sorted_value,
  output logic                     out_final_res,
  output logic                     out_overflow
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  best_idx_r, best_idx_nxt;
  logic signed [DATA_W-1:0] best_val_r, best_val_nxt;
  logic signed [DATA_W-1:0] pos_val_r, pos_val_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_val;

  logic             accept;
  logic             has_room;
  logic [CNT_W-1:0] count_after;
  logic [CNT_W-1:0] pos_inc;
  logic             more_pos;
  logic             emit_last;

  assign accept      = start && (state_r == S_IDLE);
  assign has_room    = (count_r < DEPTH_CNT);
  assign count_after = has_room ? count_r + ONE_CNT : count_r;
  assign pos_inc     = pos_r + ONE_CNT;
  // Another position remains when at least two elements are left after it.
  assign more_pos    = (pos_inc + ONE_CNT) < count_r;
  assign emit_last   = (pos_inc == count_r);
  assign rd_val      = signed'(ram_rdata);

  // Element store.
  ssort_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_last) begin
          state_nxt = (count_after >= TWO_CNT) ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD:  state_nxt = S_FIRST;
      S_FIRST: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_r >= count_r) begin
          state_nxt = S_SWAP1;
        end
      end
      S_SWAP1: begin
        if (best_idx_r != pos_r) begin
          state_nxt = S_SWAP2;
        end else begin
          state_nxt = more_pos ? S_LOAD : S_EMIT;
        end
      end
      S_SWAP2: state_nxt = more_pos ? S_LOAD : S_EMIT;
      S_EMIT: begin
        if (emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control: store ports, counters, running minimum and results.
  always_comb begin
    count_nxt      = count_r;
    drop_nxt       = drop_r;
    pos_nxt        = pos_r;
    scan_nxt       = scan_r;
    rd_idx_nxt     = rd_idx_r;
    best_idx_nxt   = best_idx_r;
    best_val_nxt   = best_val_r;
    pos_val_nxt    = pos_val_r;
    out_strobe_nxt = 1'b0;
    out_final_nxt  = out_final_r;
    out_ovf_nxt    = out_ovf_r;
    ram_we         = 1'b0;
    ram_waddr      = count_r[ADDR_W-1:0];
    ram_wdata      = in_value;
    ram_re         = 1'b0;
    ram_raddr      = pos_r[ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        // Store the value while there is room, otherwise note the drop.
        if (accept) begin
          ram_we    = has_room;
          count_nxt = count_after;
          drop_nxt  = drop_r || !has_room;
          pos_nxt   = '0;
        end
      end
      S_LOAD: begin
        ram_re   = 1'b1;
        scan_nxt = pos_inc;
      end
      S_FIRST: begin
        // The element at the position is the first candidate minimum.
        best_val_nxt = rd_val;
        best_idx_nxt = pos_r;
        pos_val_nxt  = rd_val;
        ram_re       = 1'b1;
        ram_raddr    = scan_r[ADDR_W-1:0];
        rd_idx_nxt   = scan_r;
        scan_nxt     = scan_r + ONE_CNT;
      end
      S_SCAN: begin
        // Compare the returning element, and keep the read pipeline full.
        if (rd_val < best_val_r) begin
          best_val_nxt = rd_val;
          best_idx_nxt = rd_idx_r;
        end
        if (scan_r < count_r) begin
          ram_re     = 1'b1;
          ram_raddr  = scan_r[ADDR_W-1:0];
          rd_idx_nxt = scan_r;
          scan_nxt   = scan_r + ONE_CNT;
        end
      end
      S_SWAP1: begin
        if (best_idx_r != pos_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[ADDR_W-1:0];
          ram_wdata = best_val_r;
        end else begin
          pos_nxt = more_pos ? pos_inc : '0;
        end
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx_r[ADDR_W-1:0];
        ram_wdata = pos_val_r;
        pos_nxt   = more_pos ? pos_inc : '0;
      end
      S_EMIT: begin
        // Each read returns the next result on the following cycle.
        ram_re         = 1'b1;
        out_strobe_nxt = 1'b1;
        out_final_nxt  = emit_last;
        out_ovf_nxt    = drop_r;
        pos_nxt        = pos_inc;
        if (emit_last) begin
          count_nxt = '0;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      drop_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      drop_r       <= drop_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    scan_r     <= scan_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    pos_val_r  <= pos_val_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_sorted_value = rd_val;
  assign out_final_res    = out_final_r;
  assign out_overflow     = out_ovf_r;

  // The element count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("element count exceeds store depth");

  // A sort or emission only runs on a nonempty set.
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (count_r != '0))
    else $error("sequencer busy with an empty set");

  // The engine only leaves collection after a transaction marked last.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_last))
    else $error("sequencer started without a last value");

  // Scan reads stay inside the stored set and after the current position.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r < count_r) && (rd_idx_r > pos_r))
    else $error("scan index outside the unsorted range");

  // The final result is followed by collection, never by another result.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_final_res) |-> (state_r == S_IDLE))
    else $error("emission continued past the final result");

endmodule

// File: dv/selection_sort_engine_test.sv
// Self-checking testbench for the selection sort engine: directed and random sets of
// signed values are fed through start/busy, and every strobed result is checked.
// Depends on ssort_pkg and the selection_sort_engine RTL in hdl.
`timescale 1ns / 1ps

module selection_sort_engine_test;
  import ssort_pkg::*;

  localparam int RANDOM_ITEMS = 388;
  localparam int DRAIN_CYCLES = 2500;
  localparam int REPORT_LIMIT = 10;
  localparam int DIRECTED_ROWS = 22;

  localparam logic [DATA_W-1:0] MAX_VAL = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic [DATA_W-1:0] NEG_ONE = 32'hFFFF_FFFF;

  // One sorted element as the engine should emit it.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     final_res;
    logic                     overflow;
  } sorted_result_t;

  // One directed transaction; typed rows are single-value sets whose result is obvious.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] typed_value;
  } stim_row_t;

  localparam stim_row_t STIM_ROWS [DIRECTED_ROWS] = '{
    // Single-value sets right after reset, at the extremes.
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{MAX_VAL,       1'b1, 1'b1, MAX_VAL},
    '{MIN_VAL,       1'b1, 1'b1, MIN_VAL},
    '{NEG_ONE,       1'b1, 1'b1, NEG_ONE},
    // Both extremes mixed with zero and minus one.
    '{MAX_VAL,       1'b0, 1'b0, '0},
    '{MIN_VAL,       1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{NEG_ONE,       1'b1, 1'b0, '0},
    // All values equal.
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b0, 1'b0, '0},
    '{32'h0000_0005, 1'b1, 1'b0, '0},
    // Descending input, the outer values swap.
    '{32'h0000_0003, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0},
    // Already in order, no swaps.
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b1, 1'b0, '0},
    // Duplicated extremes.
    '{MIN_VAL,       1'b0, 1'b0, '0},
    '{MIN_VAL,       1'b0, 1'b0, '0},
    '{MAX_VAL,       1'b1, 1'b0, '0},
    // Alternating bit patterns.
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h0000_0001, 1'b1, 1'b0, '0}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_last;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_final_res;
  logic                     out_overflow;

  // Predictor state: the set collected so far.
  logic signed [DATA_W-1:0] set_store [DEPTH];
  int                       set_count;
  bit                       set_dropped;

  sorted_result_t           sorted_due [$];

  int error_count;
  int sets_done;
  int overflow_sets;
  int values_sent;
  int results_checked;
  int largest_set;

  selection_sort_engine u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the engine hangs.
  initial begin
    #5_000_000;
    $display("selection_sort_engine test failed");
    $finish;
  end

  // Store one accepted value; at the end of a set, sort it and queue its results.
  task automatic take_value(input logic signed [DATA_W-1:0] v, input logic l,
                            input logic typed, input logic signed [DATA_W-1:0] typed_value);
    logic signed [DATA_W-1:0] ordered [DEPTH];
    logic signed [DATA_W-1:0] held;
    sorted_result_t           res;
    int                       n;
    int                       pos;
    int                       scan;
    int                       best;
    values_sent++;
    if (set_count < DEPTH) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!l) return;

    n = set_count;
    for (pos = 0; pos < n; pos++) ordered[pos] = set_store[pos];
    for (pos = 0; pos + 1 < n; pos++) begin
      best = pos;
      for (scan = pos + 1; scan < n; scan++) begin
        if (ordered[scan] < ordered[best]) best = scan;
      end
      held          = ordered[pos];
      ordered[pos]  = ordered[best];
      ordered[best] = held;
    end

    if (typed) begin
      res.value     = typed_value;
      res.final_res = 1'b1;
      res.overflow  = 1'b0;
      sorted_due.push_back(res);
    end else begin
      for (pos = 0; pos < n; pos++) begin
        res.value     = ordered[pos];
        res.final_res = (pos == n - 1);
        res.overflow  = set_dropped;
        sorted_due.push_back(res);
      end
    end

    sets_done++;
    if (set_dropped) overflow_sets++;
    if (set_count + (set_dropped ? 1 : 0) > largest_set) largest_set = set_count;
    set_count   = 0;
    set_dropped = 1'b0;
  endtask

  // Present one value after a gap and hold it until the engine takes it.
  task automatic send_value(input logic signed [DATA_W-1:0] v, input logic l, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop sending until every outstanding result has come out; the first edge
  // is always waited so that start is driven at most once per time step.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
  endtask

  function automatic int draw_gap(bit eager);
    return eager ? 0 : $urandom_range(0, 8);
  endfunction

  // Value mixes: full range, a narrow band full of duplicates, extremes, near the ends.
  function automatic logic signed [DATA_W-1:0] draw_value(int flavor);
    int pick;
    case (flavor)
      0: return $urandom;
      1: return $signed($urandom_range(0, 15)) - 8;
      2: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return MAX_VAL;
          1: return MIN_VAL;
          2: return '0;
          3: return NEG_ONE;
          default: return $urandom;
        endcase
      end
      default: begin
        if ($urandom_range(0, 1) == 0) return MIN_VAL + $urandom_range(0, 7);
        return MAX_VAL - $urandom_range(0, 7);
      end
    endcase
  endfunction

  // Check every strobed result against the oldest queued one.
  always @(posedge clk) begin
    sorted_result_t want;
    if (rst_n && out_strobe) begin
      if (sorted_due.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("ERROR: unexpected result value=%0d final_res=%0b overflow=%0b",
                   out_sorted_value, out_final_res, out_overflow);
      end else begin
        want = sorted_due.pop_front();
        results_checked++;
        if (out_sorted_value !== want.value || out_final_res !== want.final_res ||
            out_overflow !== want.overflow) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("ERROR: result %0d: expected value=%0d final_res=%0b overflow=%0b, %s",
                     results_checked, want.value, want.final_res, want.overflow,
                     $sformatf("got value=%0d final_res=%0b overflow=%0b",
                               out_sorted_value, out_final_res, out_overflow));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int  row;
    int  random_items;
    int  set_index;
    int  set_len;
    int  flavor;
    int  k;
    bit  eager;
    logic signed [DATA_W-1:0] v;

    error_count     = 0;
    sets_done       = 0;
    overflow_sets   = 0;
    values_sent     = 0;
    results_checked = 0;
    largest_set     = 0;
    set_count       = 0;
    set_dropped     = 1'b0;
    random_items    = 0;
    set_index       = 0;

    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    in_last  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    for (row = 0; row < DIRECTED_ROWS; row++) begin
      send_value(STIM_ROWS[row].value, STIM_ROWS[row].last, $urandom_range(0, 2));
      take_value(STIM_ROWS[row].value, STIM_ROWS[row].last, STIM_ROWS[row].typed,
                 STIM_ROWS[row].typed_value);
    end
    drain_results();

    // Random sets: mostly short, a few near, at or past the store depth.
    while (random_items < RANDOM_ITEMS) begin
      case (set_index)
        2: set_len = DEPTH;
        5: set_len = DEPTH + 1;
        9: set_len = DEPTH + 3;
        default: begin
          if ($urandom_range(0, 24) == 0) set_len = $urandom_range(DEPTH - 4, DEPTH + 4);
          else set_len = $urandom_range(1, 10);
        end
      endcase
      flavor = $urandom_range(0, 3);
      eager  = ($urandom_range(0, 3) == 0);
      for (k = 0; k < set_len; k++) begin
        v = draw_value(flavor);
        send_value(v, (k == set_len - 1), draw_gap(eager));
        take_value(v, (k == set_len - 1), 1'b0, '0);
        random_items++;
      end
      if (set_index == 3 || $urandom_range(0, 7) == 0) drain_results();
      set_index++;
    end

    // Let everything drain, then watch for stray results.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d sets built from %0d values; %0d results checked.",
             sets_done, values_sent, results_checked);
    $display("%0d sets overflowed the store; the largest set held %0d values.",
             overflow_sets, largest_set);
    if (error_count == 0 && sorted_due.size() == 0) begin
      $display("selection_sort_engine test passed");
    end else begin
      $display("selection_sort_engine test failed");
    end
    $finish;
  end

endmodule
